FILE: rtl/core/utf8_code_point_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_core_defines.svh
// Assertion macros shared by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODE_POINT_DECODER_CORE_DEFINES_SVH
`define UTF8_CODE_POINT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted (active-low reset)
`define U8DEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well
`define U8DEC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 16;
    localparam int unsigned MaxRes = 3;

    // Byte class masks and patterns
    localparam logic [ByteW-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [ByteW-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [ByteW-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [ByteW-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [ByteW-1:0] CONT_MASK  = 8'hC0;
    localparam logic [ByteW-1:0] CONT_PAT   = 8'h80;
    localparam logic [ByteW-1:0] END_BYTE   = 8'h00;

    // Pending-sequence state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,  // no sequence pending
        ST_LEAD2 = 4'b0010,  // two-byte lead held
        ST_LEAD3 = 4'b0100,  // three-byte lead held, waiting for second byte
        ST_THIRD = 4'b1000   // lead and second byte held, waiting for third
    } t_mode;

    // One result item
    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           malformed;
        logic           last_of_run;
    } t_result;

    localparam t_result RES_MALFORMED = '{code_point: '0, malformed: 1'b1,
                                          last_of_run: 1'b0};

    function automatic logic is_cont(input logic [ByteW-1:0] b);
        return (b & CONT_MASK) == CONT_PAT;
    endfunction

    function automatic t_result raw_result(input logic [ByteW-1:0] b);
        t_result r;
        r.code_point  = {{(CpW-ByteW){1'b0}}, b};
        r.malformed   = 1'b0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/core/utf8_code_point_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_core
// Decodes a UTF-8 byte stream (up to three-byte sequences) to code points.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_axis channel, one per transaction. Each byte yields
//   zero to three results on the m_axis channel: a 16-bit code point in
//   tdata, the malformed flag in tuser and tlast on the final result that
//   byte caused. Leads and middle bytes of a sequence, and the zero
//   end-of-text byte, may yield nothing.
//   A byte's first result is registered and shown the cycle after its acceptance.
//   Throughput: one byte per cycle while each byte yields at most one
//   result and the receiver is ready; a byte that yields k results holds the
//   input while the three-entry result buffer drains one entry per ready cycle.
//   A new byte is taken in the same cycle the last buffered result leaves.
//   When the receiver stalls, the buffered results hold and the input stops
//   accepting once the buffer cannot drain.
//   Reset (synchronous, active low) empties the result buffer and drops any
//   pending sequence.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_core
    import u8dec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input byte stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [ByteW-1:0] i_s_axis_tdata,   // [7:0] text_byte
    // Output code point stream
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [CpW-1:0]   o_m_axis_tdata,   // [15:0] code_point
    output logic             o_m_axis_tuser,   // [0] malformed
    output logic             o_m_axis_tlast    // last_of_run
);

    t_mode            r_mode, n_mode;
    logic [ByteW-1:0] r_held_lead, n_held_lead;
    logic [ByteW-1:0] r_held_second, n_held_second;
    t_result          r_res [MaxRes];
    logic [1:0]       r_cnt;

    logic             w_accept, w_pop;
    logic [ByteW-1:0] w_byte;
    logic             w_cont, w_fresh;
    t_result          w_pre0, w_pre1;
    logic [1:0]       w_pre_cnt;
    t_result          w_load [MaxRes];
    logic [1:0]       w_load_cnt;
    t_result          w_cp2, w_cp3;

    // Handshakes
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tdata  = r_res[0].code_point;
    assign o_m_axis_tuser  = r_res[0].malformed;
    assign o_m_axis_tlast  = r_res[0].last_of_run;

    assign w_byte = i_s_axis_tdata;
    assign w_cont = is_cont(w_byte);

    // Completed sequences
    always_comb begin
        w_cp2 = '{code_point: {5'd0, r_held_lead[4:0], w_byte[5:0]},
                  malformed: 1'b0, last_of_run: 1'b0};
        w_cp3 = '{code_point: {r_held_lead[3:0], r_held_second[5:0], w_byte[5:0]},
                  malformed: 1'b0, last_of_run: 1'b0};
    end

    // Pending-sequence step: results owed before the byte is seen fresh
    always_comb begin
        n_mode        = r_mode;
        n_held_lead   = r_held_lead;
        n_held_second = r_held_second;
        w_pre0        = RES_MALFORMED;
        w_pre1        = raw_result(r_held_second);
        w_pre_cnt     = 2'd0;
        w_fresh       = 1'b0;
        unique case (r_mode)
            ST_LEAD2: begin
                w_pre_cnt = 2'd1;
                if (w_cont) begin
                    w_pre0 = w_cp2;
                    n_mode = ST_IDLE;
                end else begin
                    w_fresh = 1'b1;
                end
            end
            ST_LEAD3: begin
                if (w_cont) begin
                    n_held_second = w_byte;
                    n_mode        = ST_THIRD;
                end else begin
                    w_pre_cnt = 2'd1;
                    w_fresh   = 1'b1;
                end
            end
            ST_THIRD: begin
                if (w_cont) begin
                    w_pre0    = w_cp3;
                    w_pre_cnt = 2'd1;
                    n_mode    = ST_IDLE;
                end else begin
                    w_pre_cnt = 2'd2;
                    w_fresh   = 1'b1;
                end
            end
            ST_IDLE: begin
                w_fresh = 1'b1;
            end
            default: begin
                w_fresh = 1'b1;
            end
        endcase

        // Byte handled as if idle
        w_load[0]  = w_pre0;
        w_load[1]  = w_pre1;
        w_load[2]  = raw_result(w_byte);
        w_load_cnt = w_pre_cnt;
        if (w_fresh) begin
            n_mode = ST_IDLE;
            if (w_byte == END_BYTE) begin
                n_mode = ST_IDLE;
            end else if ((w_byte & LEAD2_MASK) == LEAD2_PAT) begin
                n_held_lead = w_byte;
                n_mode      = ST_LEAD2;
            end else if ((w_byte & LEAD3_MASK) == LEAD3_PAT) begin
                n_held_lead = w_byte;
                n_mode      = ST_LEAD3;
            end else begin
                case (w_pre_cnt)
                    2'd0:    w_load[0] = raw_result(w_byte);
                    2'd1:    w_load[1] = raw_result(w_byte);
                    default: w_load[2] = raw_result(w_byte);
                endcase
                w_load_cnt = w_pre_cnt + 2'd1;
            end
        end

        // Mark the final result of this byte
        case (w_load_cnt)
            2'd1:    w_load[0].last_of_run = 1'b1;
            2'd2:    w_load[1].last_of_run = 1'b1;
            2'd3:    w_load[2].last_of_run = 1'b1;
            default: w_load[0].last_of_run = 1'b0;
        endcase
    end

    // Control state and held bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ST_IDLE;
            r_cnt         <= 2'd0;
            r_held_lead   <= '0;
            r_held_second <= '0;
        end else if (w_accept) begin
            r_mode        <= n_mode;
            r_cnt         <= w_load_cnt;
            r_held_lead   <= n_held_lead;
            r_held_second <= n_held_second;
        end else if (w_pop) begin
            r_cnt  <= r_cnt - 2'd1;
        end
    end

    // Result buffer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res[0]      <= w_load[0];
            r_res[1]      <= w_load[1];
            r_res[2]      <= w_load[2];
        end else if (w_pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

FILE: rtl/core/u8dec_checker.sv
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level assertions for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`include "utf8_code_point_decoder_core_defines.svh"

module u8dec_checker
    import u8dec_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [CpW-1:0]   o_m_axis_tdata,
    input logic             o_m_axis_tuser,
    input logic             o_m_axis_tlast
);

    // Reset empties the result buffer
    `U8DEC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "output valid after reset")

    // A malformed result always carries code point zero
    `U8DEC_ASSERT_IMPLY(a_malformed_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0, "malformed result with nonzero code point")

    // A stalled result holds its payload
    `U8DEC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result changed")

    // Input is taken only once the buffered run has ended
    `U8DEC_ASSERT_IMPLY(a_accept_at_end, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && o_m_axis_tvalid, i_m_axis_tready && o_m_axis_tlast, "byte accepted while results of previous byte remain")

endmodule

bind utf8_code_point_decoder_core u8dec_checker u_u8dec_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
